@@ rtl/srpw_pkg.sv @@
// Package for the sprite row pixel writer: word types for the input and result
// channels, configuration indices and fixed constants. No dependencies.
package srpw_pkg;

	localparam int unsigned PIX_PER_WORD = 4;
	localparam int unsigned PIX_IDX_W    = $clog2(PIX_PER_WORD);
	localparam int unsigned COL_W        = 11;
	localparam int unsigned CLIP_W       = 9;
	localparam int unsigned CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FLIP_SCREEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT  = 2'd2;

	localparam logic [CLIP_W-1:0] CLIP_RIGHT_RST = 9'd319;
	localparam logic [5:0]        PAL_SHADOW     = 6'h3f;
	localparam logic [3:0]        PEN_CLEAR      = 4'h0;
	localparam logic [3:0]        PEN_STOP       = 4'hf;

	typedef struct packed {
		logic        row_start;
		logic [8:0]  raw_x;
		logic        reverse_nibbles;
		logic [5:0]  palette_sel;
		logic [1:0]  priority_sel;
		logic [15:0] pixel_word;
		logic [7:0]  dest_pri_a;
		logic [7:0]  dest_pri_b;
		logic [7:0]  dest_pri_c;
		logic [7:0]  dest_pri_d;
	} item_word_t;

	typedef struct packed {
		logic signed [10:0] column;
		logic               write_pixel;
		logic               shadow_op;
		logic [10:0]        pen;
		logic               row_done;
		logic               last_of_word;
	} res_word_t;

endpackage

@@ rtl/sprite_row_pixel_writer.sv @@
// Sprite row pixel writer top level: cursor/stop state, per-word pixel
// evaluation and a four-entry result buffer. Depends on srpw_pkg.
//
// Latency: first result of a word is offered the cycle after the word is taken.
// Throughput: a word that yields pixels occupies the result buffer until its
// fourth result leaves; the next word is taken in the cycle the fourth result leaves.
// Words that yield no pixels do not enter the buffer. Reset: stopped until a row start,
// cursor zero, flip off, clip 0..319, result buffer empty.
module sprite_row_pixel_writer #(
	parameter int unsigned SCREEN_WIDTH = 320,
	parameter int unsigned X_OFFSET     = 189
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  srpw_pkg::item_word_t                 item_word,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output srpw_pkg::res_word_t                  res_word,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [srpw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [srpw_pkg::CLIP_W-1:0]          cfg_data
);

	localparam int unsigned N  = srpw_pkg::PIX_PER_WORD;
	localparam int unsigned CW = srpw_pkg::COL_W;

	logic                          flip_q;
	logic [srpw_pkg::CLIP_W-1:0]   clip_left_q;
	logic [srpw_pkg::CLIP_W-1:0]   clip_right_q;
	logic [CW-1:0]                 cursor_q;
	logic                          stopped_q;
	logic                          busy_q;
	logic [srpw_pkg::PIX_IDX_W-1:0] idx_q;
	srpw_pkg::res_word_t           res_s1 [N];

	logic          drain, free, accept;
	logic [CW-1:0] start_col, cur_col, end_col;
	logic          stop_pre, stop_post;
	logic [3:0]    pix   [N];
	logic [7:0]    dpri  [N];
	logic [CW-1:0] col   [N];
	logic          wr    [N];
	logic [7:0]    sprpri;

	function automatic logic past_far(input logic [CW-1:0] x, input logic flip,
			input logic [srpw_pkg::CLIP_W-1:0] cl, input logic [srpw_pkg::CLIP_W-1:0] cr);
		logic signed [CW:0] sx, sl, sr;
		sx = $signed({x[CW-1], x});
		sl = $signed({(CW+1-srpw_pkg::CLIP_W)'(0), cl});
		sr = $signed({(CW+1-srpw_pkg::CLIP_W)'(0), cr});
		return flip ? (sx < sl) : (sx > sr);
	endfunction

	function automatic logic in_clip(input logic [CW-1:0] x,
			input logic [srpw_pkg::CLIP_W-1:0] cl, input logic [srpw_pkg::CLIP_W-1:0] cr);
		logic signed [CW:0] sx, sl, sr;
		sx = $signed({x[CW-1], x});
		sl = $signed({(CW+1-srpw_pkg::CLIP_W)'(0), cl});
		sr = $signed({(CW+1-srpw_pkg::CLIP_W)'(0), cr});
		return (sx >= sl) && (sx <= sr);
	endfunction

	assign cfg_ready  = 1'b1;
	assign drain      = busy_q && !res_stall && (idx_q == srpw_pkg::PIX_IDX_W'(N - 1));
	assign free       = !busy_q || drain;
	assign item_stall = !free;
	assign accept     = item_valid && free;
	assign res_valid  = busy_q;
	assign res_word   = res_s1[idx_q];

	always_comb begin
		start_col = CW'(item_word.raw_x) - CW'(X_OFFSET);
		if (flip_q) begin
			start_col = CW'(SCREEN_WIDTH) - start_col;
		end
		cur_col  = item_word.row_start ? start_col : cursor_q;
		stop_pre = item_word.row_start ? past_far(start_col, flip_q, clip_left_q, clip_right_q)
		                               : stopped_q;
		end_col  = flip_q ? cur_col - CW'(N) : cur_col + CW'(N);
		sprpri   = 8'(1) << item_word.priority_sel;
		dpri[0]  = item_word.dest_pri_a;
		dpri[1]  = item_word.dest_pri_b;
		dpri[2]  = item_word.dest_pri_c;
		dpri[3]  = item_word.dest_pri_d;
		for (int k = 0; k < N; k++) begin
			pix[k] = item_word.reverse_nibbles ? item_word.pixel_word[4*k +: 4]
			                                   : item_word.pixel_word[4*(N-1-k) +: 4];
			col[k] = flip_q ? cur_col - CW'(k) : cur_col + CW'(k);
			wr[k]  = in_clip(col[k], clip_left_q, clip_right_q) &&
			         (pix[k] != srpw_pkg::PEN_CLEAR) && (pix[k] != srpw_pkg::PEN_STOP) &&
			         (sprpri > dpri[k]);
		end
		stop_post = (pix[N-1] == srpw_pkg::PEN_STOP) ||
		            past_far(end_col, flip_q, clip_left_q, clip_right_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q       <= 1'b0;
			clip_left_q  <= '0;
			clip_right_q <= srpw_pkg::CLIP_RIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				srpw_pkg::CFG_FLIP_SCREEN: flip_q       <= cfg_data[0];
				srpw_pkg::CFG_CLIP_LEFT:   clip_left_q  <= cfg_data;
				srpw_pkg::CFG_CLIP_RIGHT:  clip_right_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q  <= '0;
			stopped_q <= 1'b1;
			busy_q    <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (accept) begin
				if (stop_pre) begin
					cursor_q  <= cur_col;
					stopped_q <= 1'b1;
					busy_q    <= 1'b0;
				end else begin
					cursor_q  <= end_col;
					stopped_q <= stop_post;
					busy_q    <= 1'b1;
				end
				idx_q <= '0;
			end else if (drain) begin
				busy_q <= 1'b0;
			end else if (busy_q && !res_stall) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// result buffer payload, no reset
	always_ff @(posedge clk) begin
		if (accept && !stop_pre) begin
			for (int k = 0; k < N; k++) begin
				res_s1[k].column       <= $signed(col[k]);
				res_s1[k].write_pixel  <= wr[k];
				res_s1[k].shadow_op    <= (item_word.palette_sel == srpw_pkg::PAL_SHADOW);
				res_s1[k].pen          <= {1'b1, item_word.palette_sel, pix[k]};
				res_s1[k].row_done     <= stop_post;
				res_s1[k].last_of_word <= (k == N - 1);
			end
		end
	end

endmodule

@@ rtl/srpw_checker.sv @@
// Port-level checker for the sprite row pixel writer, bound to the top level.
// Depends on srpw_pkg.
module srpw_port_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           item_valid,
	input logic                           item_stall,
	input srpw_pkg::item_word_t           item_word,
	input logic                           res_valid,
	input logic                           res_stall,
	input srpw_pkg::res_word_t            res_word,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [srpw_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [srpw_pkg::CLIP_W-1:0]    cfg_data
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_word))
		else $error("stalled result changed");

	a_word_continues: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res_word.last_of_word |=> res_valid)
		else $error("word ended before its fourth result");

	a_row_done_steady: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res_word.last_of_word
		|=> res_word.row_done == $past(res_word.row_done))
		else $error("row_done changed within a word");

	a_no_write_transparent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.write_pixel
		|-> res_word.pen[3:0] != srpw_pkg::PEN_CLEAR && res_word.pen[3:0] != srpw_pkg::PEN_STOP)
		else $error("transparent pen written");

	a_take_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !item_stall)
		else $error("input stalled with empty result buffer");

endmodule

bind sprite_row_pixel_writer srpw_port_checker u_srpw_checker (.*);
